>>> src/mpf_pkg.sv
// Shared types and constants for the monochrome page framebuffer.
// Holds the opcode and state encodings; no dependencies.
`timescale 1ns / 1ps

package mpf_pkg;

  localparam int ROWS_PER_PAGE = 8;
  localparam int POS_BITS      = 8;

  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_GET_PIXEL = 3'd1,
    OP_HSPAN     = 3'd2,
    OP_VSPAN     = 3'd3,
    OP_READ_BYTE = 3'd4
  } opcode_t;

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_BLACK = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_READ,
    ST_RESULT
  } state_t;

endpackage

>>> src/mono_page_framebuffer.sv
// Monochrome page-organized framebuffer, 1 bit per pixel, eight rows per byte.
// Uses mpf_pkg for opcodes and states.
//
// Command channel (cmd_valid/cmd_ready) takes one word per operation: set pixel,
// get pixel, horizontal span, vertical span, read byte. Get pixel and read byte
// each return one word on the response channel (rsp_valid/rsp_ready); the other
// operations return nothing.
// All work goes through one synchronous store (one read, one write port).
// A span issues one store read per covered column (horizontal) or per touched
// page (vertical) in back-to-back cycles, with the write-back in the cycle after each read.
// cmd_ready is high only in the idle step, so no new word is taken while a span or read is under way.
// Reads go through the read and result steps; the response word is registered.
// A stalled response holds the block in its result step until the word is taken.
// After reset the store is cleared one byte per cycle, all 2**(page bits + column
// bits) bytes (1024 at 128 x 64); cmd_ready stays low until then.
`timescale 1ns / 1ps

module mono_page_framebuffer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [2:0] opcode,
  input  logic [1:0] color,
  input  logic [6:0] col,
  input  logic [5:0] row,
  input  logic [7:0] span_end,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] read_value
);

  localparam int PAGE_COUNT = (SCREEN_HEIGHT + mpf_pkg::ROWS_PER_PAGE - 1)
                              / mpf_pkg::ROWS_PER_PAGE;
  localparam int COL_BITS   = $clog2(SCREEN_WIDTH);
  localparam int PAGE_BITS  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_BITS  = PAGE_BITS + COL_BITS;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int PB         = mpf_pkg::POS_BITS;

  mpf_pkg::state_t state, state_next;

  logic [7:0]           mem [MEM_DEPTH];
  logic [7:0]           mem_rdata;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0]           mem_wdata;

  logic [ADDR_BITS-1:0] clr_addr;

  // span walker
  logic                 span_vert;
  logic [PB-1:0]        cur;
  logic [PB-1:0]        lim;
  logic [PAGE_BITS-1:0] fix_page;
  logic [COL_BITS-1:0]  fix_col;
  logic [7:0]           fix_mask;
  logic [1:0]           span_color;

  // write-back stage
  logic                 wb_valid;
  logic [ADDR_BITS-1:0] wb_addr;
  logic [7:0]           wb_mask;
  logic [1:0]           wb_color;

  // read operation
  logic                 rd_on;
  logic                 rd_byte;
  logic [2:0]           rd_bit;
  logic [ADDR_BITS-1:0] rd_addr;

  // decode of the incoming word
  logic                 accept;
  logic                 col_on, row_on;
  logic                 setup_vert;
  logic [PB-1:0]        setup_cur;
  logic [PB-1:0]        setup_lim;
  logic                 setup_empty;
  logic [PB-1:0]        lim_w, lim_h;

  // current span element
  logic [ADDR_BITS-1:0] elem_addr;
  logic [7:0]           elem_mask;
  logic [7:0]           mask_lo, mask_hi;
  logic [PB:0]          pos_next;
  logic                 span_last;
  logic [7:0]           result;

  assign accept = cmd_valid && cmd_ready;
  assign col_on = 9'(col) < 9'(SCREEN_WIDTH);
  assign row_on = 9'(row) < 9'(SCREEN_HEIGHT);
  assign lim_w  = (9'(span_end) < 9'(SCREEN_WIDTH))  ? span_end : PB'(SCREEN_WIDTH);
  assign lim_h  = (9'(span_end) < 9'(SCREEN_HEIGHT)) ? span_end : PB'(SCREEN_HEIGHT);

  always_comb begin
    setup_vert  = 1'b0;
    setup_cur   = PB'(col);
    setup_lim   = PB'(col) + PB'(1);
    setup_empty = 1'b1;
    case (mpf_pkg::opcode_t'(opcode))
      mpf_pkg::OP_SET_PIXEL: begin
        setup_empty = !(col_on && row_on);
      end
      mpf_pkg::OP_HSPAN: begin
        setup_lim   = lim_w;
        setup_empty = !row_on || (PB'(col) >= lim_w);
      end
      mpf_pkg::OP_VSPAN: begin
        setup_vert  = 1'b1;
        setup_cur   = PB'(row);
        setup_lim   = lim_h;
        setup_empty = !col_on || (PB'(row) >= lim_h);
      end
      default: begin
        setup_empty = 1'b1;
      end
    endcase
  end

  // span element: a column of one page, or the rows of one page in one column
  always_comb begin
    mask_lo = 8'hFF << cur[2:0];
    mask_hi = (lim[PB-1:3] == cur[PB-1:3]) ? ((8'd1 << lim[2:0]) - 8'd1) : 8'hFF;
    if (span_vert) begin
      elem_addr = {PAGE_BITS'(cur[PB-1:3]), fix_col};
      elem_mask = mask_lo & mask_hi;
      pos_next  = {(6'(cur[PB-1:3]) + 6'd1), 3'd0};
    end else begin
      elem_addr = {fix_page, cur[COL_BITS-1:0]};
      elem_mask = fix_mask;
      pos_next  = (PB+1)'(cur) + (PB+1)'(1);
    end
    span_last = pos_next >= (PB+1)'(lim);
  end

  always_comb begin
    state_next = state;
    case (state)
      mpf_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = mpf_pkg::ST_IDLE;
      end
      mpf_pkg::ST_IDLE: begin
        if (accept) begin
          case (mpf_pkg::opcode_t'(opcode))
            mpf_pkg::OP_SET_PIXEL, mpf_pkg::OP_HSPAN, mpf_pkg::OP_VSPAN: begin
              if (!setup_empty) state_next = mpf_pkg::ST_SPAN;
            end
            mpf_pkg::OP_GET_PIXEL, mpf_pkg::OP_READ_BYTE: begin
              state_next = mpf_pkg::ST_READ;
            end
            default: state_next = mpf_pkg::ST_IDLE;
          endcase
        end
      end
      mpf_pkg::ST_SPAN: begin
        if (span_last) state_next = mpf_pkg::ST_IDLE;
      end
      mpf_pkg::ST_READ: begin
        state_next = mpf_pkg::ST_RESULT;
      end
      mpf_pkg::ST_RESULT: begin
        if (!rsp_valid || rsp_ready) state_next = mpf_pkg::ST_IDLE;
      end
      default: state_next = mpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    case (state)
      mpf_pkg::ST_IDLE: cmd_ready = 1'b1;
      mpf_pkg::ST_SPAN: begin
        mem_re    = 1'b1;
        mem_raddr = elem_addr;
      end
      mpf_pkg::ST_READ: mem_re = rd_on;
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    mem_we    = wb_valid;
    mem_waddr = wb_addr;
    if (wb_color == mpf_pkg::COLOR_BLACK) begin
      mem_wdata = mem_rdata | wb_mask;
    end else if (wb_color == mpf_pkg::COLOR_WHITE) begin
      mem_wdata = mem_rdata & ~wb_mask;
    end else begin
      mem_wdata = mem_rdata;
    end
    if (state == mpf_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mpf_pkg::ST_CLEAR;
      clr_addr <= '0;
      wb_valid <= 1'b0;
    end else begin
      state    <= state_next;
      wb_valid <= (state == mpf_pkg::ST_SPAN);
      if (state == mpf_pkg::ST_CLEAR) clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    wb_addr  <= elem_addr;
    wb_mask  <= elem_mask;
    wb_color <= span_color;
    if (state == mpf_pkg::ST_SPAN) cur <= pos_next[PB-1:0];
    if (accept) begin
      span_vert  <= setup_vert;
      cur        <= setup_cur;
      lim        <= setup_lim;
      fix_page   <= PAGE_BITS'(row[5:3]);
      fix_col    <= COL_BITS'(col);
      fix_mask   <= 8'd1 << row[2:0];
      span_color <= color;
      rd_on      <= col_on && row_on;
      rd_byte    <= (mpf_pkg::opcode_t'(opcode) == mpf_pkg::OP_READ_BYTE);
      rd_bit     <= row[2:0];
      rd_addr    <= {PAGE_BITS'(row[5:3]), COL_BITS'(col)};
    end
  end

  assign result = !rd_on ? 8'd0 :
                  rd_byte ? mem_rdata : {7'd0, mem_rdata[rd_bit]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == mpf_pkg::ST_RESULT && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mpf_pkg::ST_RESULT && (!rsp_valid || rsp_ready)) read_value <= result;
  end

endmodule

>>> bench/tb_mono_page_framebuffer.sv
// Self-checking bench for mono_page_framebuffer: directed and random command words,
// with a shadow frame store that predicts every read word. Depends on mpf_pkg.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + mpf_pkg::ROWS_PER_PAGE - 1)
                                 / mpf_pkg::ROWS_PER_PAGE;
  localparam int IDLE_PCT      = 38;
  localparam int RANDOM_WORDS  = 840;
  localparam int SETTLE_CYCLES = 200;

  localparam logic [1:0] COLOR_KEEP     = 2'd2;
  localparam logic [1:0] COLOR_KEEP_ALT = 2'd3;
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  class pixel_shadow;
    logic [7:0] pages [PAGE_COUNT * SCREEN_WIDTH];
    logic [7:0] pending_reads [$];
    int         errors;

    function new();
      foreach (pages[i]) pages[i] = '0;
      errors = 0;
    endfunction

    function void paint(int x, int y, logic [1:0] c);
      int idx;
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
      idx = (y / mpf_pkg::ROWS_PER_PAGE) * SCREEN_WIDTH + x;
      if (c == mpf_pkg::COLOR_BLACK) pages[idx][y % mpf_pkg::ROWS_PER_PAGE] = 1'b1;
      else if (c == mpf_pkg::COLOR_WHITE) pages[idx][y % mpf_pkg::ROWS_PER_PAGE] = 1'b0;
    endfunction

    function void apply_command(logic [2:0] op, logic [1:0] c, int x, int y, int e);
      int         i;
      int         idx;
      logic [7:0] value;
      value = '0;
      idx   = (y / mpf_pkg::ROWS_PER_PAGE) * SCREEN_WIDTH + x;
      case (op)
        mpf_pkg::OP_SET_PIXEL: paint(x, y, c);
        mpf_pkg::OP_GET_PIXEL: begin
          if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
            value[0] = pages[idx][y % mpf_pkg::ROWS_PER_PAGE];
          end
          pending_reads.push_back(value);
        end
        mpf_pkg::OP_HSPAN: for (i = x; i < e && i < SCREEN_WIDTH; i++) paint(i, y, c);
        mpf_pkg::OP_VSPAN: for (i = y; i < e && i < SCREEN_HEIGHT; i++) paint(x, i, c);
        mpf_pkg::OP_READ_BYTE: begin
          if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) value = pages[idx];
          pending_reads.push_back(value);
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [7:0] actual);
      logic [7:0] wanted;
      if (pending_reads.size() == 0) begin
        $error("read_value: expected none, actual %02h", actual);
        errors++;
      end else begin
        wanted = pending_reads.pop_front();
        if (actual !== wanted) begin
          $error("read_value: expected %02h, actual %02h", wanted, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst        = 1'b1;
  logic       cmd_valid  = 1'b0;
  logic       cmd_ready;
  logic [2:0] opcode     = '0;
  logic [1:0] color      = '0;
  logic [6:0] col        = '0;
  logic [5:0] row        = '0;
  logic [7:0] span_end   = '0;
  logic       rsp_valid;
  logic       rsp_ready  = 1'b0;
  logic [7:0] read_value;
  bit         no_idle    = 1'b0;

  pixel_shadow shadow = new();

  mono_page_framebuffer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .opcode    (opcode),
    .color     (color),
    .col       (col),
    .row       (row),
    .span_end  (span_end),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .read_value(read_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) begin
      shadow.apply_command(opcode, color, int'(col), int'(row), int'(span_end));
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) shadow.check_read(read_value);
    rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_cmd(logic [2:0] op, logic [1:0] c, int x, int y, int e);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    opcode    <= op;
    color     <= c;
    col       <= x[6:0];
    row       <= y[5:0];
    span_end  <= e[7:0];
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic drain_reads();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending_reads.size() != 0);
  endtask

  function automatic int pick_col();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom_range(0, 15);
    else if (sel < 75) return $urandom_range(120, SCREEN_WIDTH - 1);
    else return $urandom_range(0, SCREEN_WIDTH - 1);
  endfunction

  function automatic int pick_row();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom_range(0, 15);
    else if (sel < 75) return $urandom_range(56, SCREEN_HEIGHT - 1);
    else return $urandom_range(0, SCREEN_HEIGHT - 1);
  endfunction

  function automatic logic [1:0] pick_color();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return mpf_pkg::COLOR_BLACK;
    else if (sel < 80) return mpf_pkg::COLOR_WHITE;
    else if (sel < 90) return COLOR_KEEP;
    else return COLOR_KEEP_ALT;
  endfunction

  // mostly short spans; some empty, some clipped at the edge
  function automatic int pick_end(int start);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return start + $urandom_range(1, 12);
    else if (sel < 75) return $urandom_range(0, start);
    else if (sel < 90) return $urandom_range(120, 255);
    else return $urandom_range(0, 255);
  endfunction

  initial begin
    int         words;
    int         sel;
    int         x;
    int         y;
    int         e;
    bit         paused;
    logic [2:0] op;
    logic [1:0] c;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // corners, color handling, clipped and empty spans, reserved opcodes
    send_cmd(mpf_pkg::OP_READ_BYTE, mpf_pkg::COLOR_WHITE, 0, 0, 0);
    send_cmd(mpf_pkg::OP_GET_PIXEL, mpf_pkg::COLOR_WHITE, 127, 63, 255);
    send_cmd(mpf_pkg::OP_SET_PIXEL, mpf_pkg::COLOR_BLACK, 0, 0, 0);
    send_cmd(mpf_pkg::OP_SET_PIXEL, mpf_pkg::COLOR_BLACK, 127, 63, 0);
    send_cmd(mpf_pkg::OP_SET_PIXEL, mpf_pkg::COLOR_BLACK, 127, 0, 0);
    send_cmd(mpf_pkg::OP_SET_PIXEL, mpf_pkg::COLOR_BLACK, 0, 63, 0);
    send_cmd(mpf_pkg::OP_GET_PIXEL, mpf_pkg::COLOR_WHITE, 0, 0, 0);
    send_cmd(mpf_pkg::OP_READ_BYTE, mpf_pkg::COLOR_WHITE, 127, 56, 0);
    send_cmd(mpf_pkg::OP_SET_PIXEL, mpf_pkg::COLOR_WHITE, 0, 0, 0);
    send_cmd(mpf_pkg::OP_SET_PIXEL, COLOR_KEEP, 127, 63, 0);
    send_cmd(mpf_pkg::OP_SET_PIXEL, COLOR_KEEP_ALT, 127, 63, 0);
    send_cmd(mpf_pkg::OP_GET_PIXEL, mpf_pkg::COLOR_WHITE, 127, 63, 0);
    send_cmd(mpf_pkg::OP_HSPAN, mpf_pkg::COLOR_BLACK, 0, 8, 128);
    send_cmd(mpf_pkg::OP_HSPAN, mpf_pkg::COLOR_BLACK, 120, 9, 255);
    send_cmd(mpf_pkg::OP_READ_BYTE, mpf_pkg::COLOR_WHITE, 127, 8, 0);
    send_cmd(mpf_pkg::OP_HSPAN, mpf_pkg::COLOR_BLACK, 50, 10, 50);
    send_cmd(mpf_pkg::OP_HSPAN, mpf_pkg::COLOR_BLACK, 60, 10, 10);
    send_cmd(mpf_pkg::OP_HSPAN, mpf_pkg::COLOR_WHITE, 10, 8, 20);
    send_cmd(mpf_pkg::OP_READ_BYTE, mpf_pkg::COLOR_WHITE, 15, 8, 0);
    send_cmd(mpf_pkg::OP_VSPAN, mpf_pkg::COLOR_BLACK, 5, 0, 64);
    send_cmd(mpf_pkg::OP_VSPAN, mpf_pkg::COLOR_BLACK, 6, 60, 255);
    send_cmd(mpf_pkg::OP_VSPAN, mpf_pkg::COLOR_BLACK, 7, 20, 3);
    send_cmd(mpf_pkg::OP_READ_BYTE, mpf_pkg::COLOR_WHITE, 6, 56, 0);
    send_cmd(OP_RESERVED_LO, mpf_pkg::COLOR_BLACK, 1, 1, 128);
    send_cmd(OP_RESERVED_HI, mpf_pkg::COLOR_BLACK, 1, 1, 128);
    send_cmd(mpf_pkg::OP_GET_PIXEL, mpf_pkg::COLOR_WHITE, 1, 1, 0);

    words  = 0;
    paused = 1'b0;
    while (words < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      x   = pick_col();
      y   = pick_row();
      c   = pick_color();
      e   = $urandom_range(0, 255);
      if (sel < 4) begin
        op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      end else begin
        words++;
        if (sel < 30) op = mpf_pkg::OP_SET_PIXEL;
        else if (sel < 52) op = mpf_pkg::OP_GET_PIXEL;
        else if (sel < 72) op = mpf_pkg::OP_READ_BYTE;
        else if (sel < 86) begin
          op = mpf_pkg::OP_HSPAN;
          e  = pick_end(x);
        end else begin
          op = mpf_pkg::OP_VSPAN;
          e  = pick_end(y);
        end
      end
      no_idle = (words >= 550 && words < 700);
      send_cmd(op, c, x, y, e);
      if (words >= 300 && !paused) begin
        paused = 1'b1;
        drain_reads();
      end
    end
    no_idle = 1'b0;

    drain_reads();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_reads.size() == 0) begin
      $display("mono_page_framebuffer verification clean");
    end else begin
      $display("mono_page_framebuffer verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mono_page_framebuffer verification failed");
    $finish;
  end

endmodule
